FILE: src/sdrk_pkg.sv
// Package for the spring-damper RK2 step block: payload types, register indexes,
// datapath opcodes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none
package sdrk_pkg;

   localparam int DataWidthDef = 32;
   localparam int FracBitsDef  = 16;

   localparam logic [2:0] REG_MASS       = 3'd0;
   localparam logic [2:0] REG_DAMPING    = 3'd1;
   localparam logic [2:0] REG_STIFFNESS  = 3'd2;
   localparam logic [2:0] REG_FORCE_GAIN = 3'd3;
   localparam logic [2:0] REG_DISP_LIMIT = 3'd4;

   // datapath operations: result goes to the accumulator register
   localparam logic [3:0] OP_MUL  = 4'd0;  // acc = smul(opa, opb)
   localparam logic [3:0] OP_ADD  = 4'd1;  // acc = sadd(opa, opb)
   localparam logic [3:0] OP_SUB  = 4'd2;  // acc = ssub(opa, opb)
   localparam logic [3:0] OP_NEG  = 4'd3;  // acc = sneg(opa)
   localparam logic [3:0] OP_HALF = 4'd4;  // acc = opa / 2, toward zero
   localparam logic [3:0] OP_DIV  = 4'd5;  // acc = sdiv(opa, opb), iterative
   localparam logic [3:0] OP_LIM  = 4'd6;  // limit check and clamp of opa
   localparam logic [3:0] OP_MOV  = 4'd7;  // acc = opa

   // operand sources
   localparam logic [3:0] SRC_ACC  = 4'd0;
   localparam logic [3:0] SRC_POS  = 4'd1;
   localparam logic [3:0] SRC_VEL  = 4'd2;
   localparam logic [3:0] SRC_DT   = 4'd3;
   localparam logic [3:0] SRC_F    = 4'd4;
   localparam logic [3:0] SRC_C    = 4'd5;
   localparam logic [3:0] SRC_K    = 4'd6;
   localparam logic [3:0] SRC_G    = 4'd7;
   localparam logic [3:0] SRC_M    = 4'd8;
   localparam logic [3:0] SRC_T0   = 4'd9;
   localparam logic [3:0] SRC_T1   = 4'd10;
   localparam logic [3:0] SRC_T2   = 4'd11;
   localparam logic [3:0] SRC_T3   = 4'd12;
   localparam logic [3:0] SRC_T4   = 4'd13;

   // destinations for the accumulator copy
   localparam logic [2:0] DST_NONE = 3'd0;
   localparam logic [2:0] DST_T0   = 3'd1;
   localparam logic [2:0] DST_T1   = 3'd2;
   localparam logic [2:0] DST_T2   = 3'd3;
   localparam logic [2:0] DST_T3   = 3'd4;
   localparam logic [2:0] DST_T4   = 3'd5;

   typedef struct packed {
      logic [30:0] time_step;
      logic [31:0] force_in;
   } req_type;

   typedef struct packed {
      logic [31:0] displacement;
      logic [31:0] speed;
      logic        limited;
      logic        saturated;
   } rsp_type;

   typedef struct packed {
      logic       load;     // capture inputs, clamp registers, clear limited, set saturated from inputs
      logic       start;    // launch op
      logic [3:0] op;
      logic [3:0] src_a;
      logic [3:0] src_b;
      logic [2:0] dst;
      logic       commit;   // write new state and form result
   } cmd_type;

   typedef struct packed {
      logic done;           // op finished, acc valid
      logic limited;        // last limit check clamped
   } sts_type;

endpackage
`default_nettype wire

FILE: src/sdrk_datapath.sv
// Datapath: operand registers, saturating add/sub, split multiplier, iterative
// restoring divider, limit clamp and state. Depends on sdrk_pkg.
`default_nettype none
module sdrk_datapath import sdrk_pkg::*; #(
   parameter int DATA_WIDTH = DataWidthDef,
   parameter int FRAC_BITS  = FracBitsDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   input  wire req_type     req,
   input  wire logic [30:0] mass,
   input  wire logic [31:0] damping,
   input  wire logic [31:0] stiffness,
   input  wire logic [31:0] force_gain,
   input  wire logic [30:0] disp_limit,
   output rsp_type          result
);
   localparam int W   = DATA_WIDTH;
   localparam int HW  = (W + 1) / 2;
   localparam int PW  = 2 * W;
   localparam int NW  = W + FRAC_BITS;           // divider numerator width
   localparam int CW  = $clog2(NW + 1);
   localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W:0] VMAX_X = {2'b00, {(W-1){1'b1}}};
   localparam logic signed [W:0] VMIN_X = {2'b11, {(W-1){1'b0}}};

   logic signed [W-1:0] pos_ff, vel_ff, dt_ff, f_ff, c_ff, k_ff, g_ff, m_ff, lim_ff;
   logic signed [W-1:0] t_ff [5];
   logic signed [W-1:0] acc_ff, acc_in;
   logic signed [W-1:0] a_ff, b_ff;
   logic                sat_ff, sat_in, lmt_ff, lmt_in;
   logic                done_ff, done_in;
   logic [3:0]          op_ff;
   logic [1:0]          mphase_ff;
   logic                busy_ff, busy_in;
   rsp_type             rsp_ff;

   // divider
   logic [NW-1:0]  dnum_ff;
   logic [W-1:0]   dden_ff;
   logic [W:0]     drem_ff;
   logic [NW-1:0]  dquo_ff;
   logic [CW-1:0]  dcnt_ff;
   logic           dneg_ff;

   // multiplier partial products (magnitudes split in halves)
   logic [W-1:0]   ma_ff, mb_ff;
   logic           mneg_ff;
   logic [PW-1:0]  macc_ff;

   function automatic logic signed [W-1:0] clamp_to_w(input logic signed [63:0] x,
                                                        output logic s);
      logic signed [63:0] mx, mn;
      mx = 64'(VMAX);
      mn = 64'(VMIN);
      s = 1'b0;
      if (x > mx) begin
         s = 1'b1;
         return VMAX;
      end
      if (x < mn) begin
         s = 1'b1;
         return VMIN;
      end
      return x[W-1:0];
   endfunction

   function automatic logic [31:0] out32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'h8000_0000;
      return x[31:0];
   endfunction

   function automatic logic signed [W-1:0] sel(input logic [3:0] s,
                                                input logic signed [W-1:0] acc);
      case (s)
         SRC_ACC: return acc;
         SRC_POS: return pos_ff;
         SRC_VEL: return vel_ff;
         SRC_DT:  return dt_ff;
         SRC_F:   return f_ff;
         SRC_C:   return c_ff;
         SRC_K:   return k_ff;
         SRC_G:   return g_ff;
         SRC_M:   return m_ff;
         SRC_T0:  return t_ff[0];
         SRC_T1:  return t_ff[1];
         SRC_T2:  return t_ff[2];
         SRC_T3:  return t_ff[3];
         SRC_T4:  return t_ff[4];
         default: return acc;
      endcase
   endfunction

   function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
      return x[W-1] ? W'(-x) : x;
   endfunction

   logic signed [W-1:0] opa_sel, opb_sel;
   always_comb begin
      opa_sel = sel(cmd.src_a, acc_ff);
      opb_sel = sel(cmd.src_b, acc_ff);
   end

   // saturate a sign/magnitude quotient or product of width n into W bits
   logic [W:0]  lim_pos, lim_neg;
   assign lim_pos = {1'b0, VMAX};
   assign lim_neg = lim_pos + (W+1)'(1);

   logic signed [W:0] sum_x, dif_x;

   logic [HW-1:0] ah, al, bh, bl;
   assign ah = HW'(ma_ff >> HW);
   assign al = HW'(ma_ff);
   assign bh = HW'(mb_ff >> HW);
   assign bl = HW'(mb_ff);
   logic [PW-1:0] pp;
   always_comb begin
      case (mphase_ff)
         2'd0:    pp = PW'(al * bl);
         2'd1:    pp = PW'(al * bh) << HW;
         2'd2:    pp = PW'(ah * bl) << HW;
         default: pp = PW'(ah * bh) << (2 * HW);
      endcase
   end

   // product fix: magnitude >> FRAC_BITS, last partial product included
   logic [PW-1:0] pshift;
   assign pshift = (macc_ff + pp) >> FRAC_BITS;

   // divider step
   logic [W:0]   rem_sh;
   logic         rem_ge;
   assign rem_sh = {drem_ff[W-1:0], dnum_ff[NW-1]};
   assign rem_ge = (rem_sh >= {1'b0, dden_ff});

   logic signed [W-1:0] lim_val, nlim;
   logic [W-1:0] amag;
   assign amag = mag(a_ff);
   assign nlim = W'(-lim_ff);

   always_comb begin
      logic [W:0] umag;
      acc_in  = acc_ff;
      sat_in  = sat_ff;
      lmt_in  = lmt_ff;
      done_in = 1'b0;
      busy_in = busy_ff;
      sum_x = {a_ff[W-1], a_ff} + {b_ff[W-1], b_ff};
      dif_x = {a_ff[W-1], a_ff} - {b_ff[W-1], b_ff};
      umag = '0;
      lim_val = a_ff[W-1] ? nlim : lim_ff;
      if (cmd.load) begin
         sat_in = (req.time_step == '0);
         lmt_in = 1'b0;
      end
      if (busy_ff) begin
         case (op_ff)
            OP_ADD: begin
               if (sum_x > VMAX_X) begin acc_in = VMAX; sat_in = 1'b1; end
               else if (sum_x < VMIN_X) begin acc_in = VMIN; sat_in = 1'b1; end
               else acc_in = sum_x[W-1:0];
               done_in = 1'b1; busy_in = 1'b0;
            end
            OP_SUB: begin
               if (dif_x > VMAX_X) begin acc_in = VMAX; sat_in = 1'b1; end
               else if (dif_x < VMIN_X) begin acc_in = VMIN; sat_in = 1'b1; end
               else acc_in = dif_x[W-1:0];
               done_in = 1'b1; busy_in = 1'b0;
            end
            OP_NEG: begin
               if (a_ff == VMIN) begin acc_in = VMAX; sat_in = 1'b1; end
               else acc_in = W'(-a_ff);
               done_in = 1'b1; busy_in = 1'b0;
            end
            OP_HALF: begin
               // bias negatives by one so the shift rounds toward zero
               acc_in = (a_ff + $signed({{(W-1){1'b0}}, a_ff[W-1]})) >>> 1;
               done_in = 1'b1; busy_in = 1'b0;
            end
            OP_MOV: begin
               acc_in = a_ff;
               done_in = 1'b1; busy_in = 1'b0;
            end
            OP_LIM: begin
               if ({1'b0, amag} >= {1'b0, lim_ff}) begin
                  lmt_in = 1'b1;
                  acc_in = lim_val;
               end else acc_in = a_ff;
               done_in = 1'b1; busy_in = 1'b0;
            end
            OP_MUL: begin
               if (mphase_ff == 2'd3) begin
                  if (pshift > PW'(mneg_ff ? lim_neg : lim_pos)) begin
                     sat_in = 1'b1;
                     acc_in = mneg_ff ? VMIN : VMAX;
                  end else begin
                     umag = pshift[W:0];
                     acc_in = mneg_ff ? W'(-umag) : umag[W-1:0];
                  end
                  done_in = 1'b1; busy_in = 1'b0;
               end
            end
            OP_DIV: begin
               if (dden_ff == '0) begin
                  sat_in = 1'b1;
                  acc_in = (a_ff == '0) ? '0 : (a_ff[W-1] ? VMIN : VMAX);
                  done_in = 1'b1; busy_in = 1'b0;
               end else if (dcnt_ff == '0) begin
                  if (dquo_ff > NW'(dneg_ff ? lim_neg : lim_pos)) begin
                     sat_in = 1'b1;
                     acc_in = dneg_ff ? VMIN : VMAX;
                  end else begin
                     umag = dquo_ff[W:0];
                     acc_in = dneg_ff ? W'(-umag) : umag[W-1:0];
                  end
                  done_in = 1'b1; busy_in = 1'b0;
               end
            end
            default: begin
               done_in = 1'b1; busy_in = 1'b0;
            end
         endcase
      end
      if (cmd.start) busy_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      logic s0, s1, s2, s3, s4, s5, s6;
      if (reset) begin
         pos_ff  <= '0;
         vel_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         sat_ff  <= 1'b0;
         lmt_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         lmt_ff  <= lmt_in;
         if (cmd.load) begin
            // fields wider than W saturate into range
            m_ff   <= clamp_to_w(64'(mass), s0);
            c_ff   <= clamp_to_w(64'($signed(damping)), s1);
            k_ff   <= clamp_to_w(64'($signed(stiffness)), s2);
            g_ff   <= clamp_to_w(64'($signed(force_gain)), s3);
            lim_ff <= clamp_to_w(64'(disp_limit), s4);
            dt_ff  <= clamp_to_w(64'(req.time_step), s5);
            f_ff   <= clamp_to_w(64'($signed(req.force_in)), s6);
            sat_ff <= sat_in | s0 | s1 | s2 | s3 | s4 | s5 | s6;
         end else begin
            sat_ff <= sat_in;
         end
         if (cmd.commit) begin
            pos_ff <= t_ff[3];
            vel_ff <= acc_ff;
            rsp_ff.displacement <= out32(64'(t_ff[3]));
            rsp_ff.speed        <= out32(64'(acc_ff));
            rsp_ff.limited      <= lmt_ff;
            rsp_ff.saturated    <= sat_ff | (W > 32 && (
               (64'(t_ff[3]) > 64'sd2147483647) || (64'(t_ff[3]) < -64'sd2147483648) ||
               (64'(acc_ff) > 64'sd2147483647) || (64'(acc_ff) < -64'sd2147483648)));
         end
      end
   end

   // payload and operation registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.start) begin
         op_ff     <= cmd.op;
         a_ff      <= opa_sel;
         b_ff      <= opb_sel;
         mphase_ff <= 2'd0;
         ma_ff     <= mag(opa_sel);
         mb_ff     <= mag(opb_sel);
         mneg_ff   <= opa_sel[W-1] ^ opb_sel[W-1];
         macc_ff   <= '0;
         dnum_ff   <= NW'(mag(opa_sel)) << FRAC_BITS;
         dden_ff   <= mag(opb_sel);
         dneg_ff   <= opa_sel[W-1] ^ opb_sel[W-1];
         drem_ff   <= '0;
         dquo_ff   <= '0;
         dcnt_ff   <= CW'(NW);
      end else if (busy_ff) begin
         if (op_ff == OP_MUL) begin
            macc_ff   <= macc_ff + pp;
            mphase_ff <= mphase_ff + 2'd1;
         end
         if (op_ff == OP_DIV && dcnt_ff != '0) begin
            // restoring step: one quotient bit
            drem_ff <= rem_ge ? rem_sh - {1'b0, dden_ff} : rem_sh;
            dquo_ff <= {dquo_ff[NW-2:0], rem_ge};
            dnum_ff <= dnum_ff << 1;
            dcnt_ff <= dcnt_ff - CW'(1);
         end
      end
      if (cmd.dst != DST_NONE) t_ff[cmd.dst - 3'd1] <= acc_ff;
   end

   assign sts.done    = done_ff;
   assign sts.limited = lmt_ff;
   assign result      = rsp_ff;
endmodule
`default_nettype wire

FILE: src/sdrk_control.sv
// Controller: microprogram sequencer that issues one datapath op at a time,
// plus the request/response handshake. Depends on sdrk_pkg.
`default_nettype none
module sdrk_control import sdrk_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd,
   input  wire sts_type sts
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;
   localparam int NSTEP = 30;

   logic [1:0] state_ff, state_in;
   logic [4:0] pc_ff, pc_in;
   logic       rv_ff, rv_in;

   typedef struct packed {
      logic [3:0] op;
      logic [3:0] a;
      logic [3:0] b;
      logic [2:0] dst;   // where the previous op's result is saved
   } uop_type;

   // each step's dst saves the result of the preceding step
   function automatic uop_type prog(input logic [4:0] i);
      case (i)
         5'd0:  return '{OP_MUL, SRC_G,   SRC_F,   DST_NONE}; // fr
         5'd1:  return '{OP_MUL, SRC_DT,  SRC_VEL, DST_T0};   // t0=fr
         5'd2:  return '{OP_HALF,SRC_ACC, SRC_ACC, DST_NONE};
         5'd3:  return '{OP_ADD, SRC_POS, SRC_ACC, DST_NONE};
         5'd4:  return '{OP_MUL, SRC_C,   SRC_VEL, DST_T1};   // t1=ym
         5'd5:  return '{OP_NEG, SRC_ACC, SRC_ACC, DST_NONE};
         5'd6:  return '{OP_MUL, SRC_K,   SRC_POS, DST_T2};   // t2=-cv
         5'd7:  return '{OP_NEG, SRC_ACC, SRC_ACC, DST_NONE};
         5'd8:  return '{OP_ADD, SRC_T2,  SRC_ACC, DST_NONE};
         5'd9:  return '{OP_ADD, SRC_ACC, SRC_T0,  DST_NONE};
         5'd10: return '{OP_DIV, SRC_ACC, SRC_M,   DST_NONE};
         5'd11: return '{OP_MUL, SRC_DT,  SRC_ACC, DST_NONE};
         5'd12: return '{OP_HALF,SRC_ACC, SRC_ACC, DST_NONE};
         5'd13: return '{OP_ADD, SRC_VEL, SRC_ACC, DST_NONE};
         5'd14: return '{OP_MUL, SRC_DT,  SRC_ACC, DST_T2};   // t2=vm
         5'd15: return '{OP_ADD, SRC_POS, SRC_ACC, DST_NONE};
         5'd16: return '{OP_MUL, SRC_C,   SRC_T2,  DST_T3};   // t3=yn
         5'd17: return '{OP_NEG, SRC_ACC, SRC_ACC, DST_NONE};
         5'd18: return '{OP_MUL, SRC_K,   SRC_T1,  DST_T4};   // t4=-c*vm
         5'd19: return '{OP_NEG, SRC_ACC, SRC_ACC, DST_NONE};
         5'd20: return '{OP_ADD, SRC_T4,  SRC_ACC, DST_NONE};
         5'd21: return '{OP_ADD, SRC_ACC, SRC_T0,  DST_NONE};
         5'd22: return '{OP_DIV, SRC_ACC, SRC_M,   DST_NONE};
         5'd23: return '{OP_MUL, SRC_DT,  SRC_ACC, DST_NONE};
         5'd24: return '{OP_ADD, SRC_VEL, SRC_ACC, DST_NONE};
         5'd25: return '{OP_LIM, SRC_T3,  SRC_T3,  DST_T4};   // t4=vn
         5'd26: return '{OP_MOV, SRC_ACC, SRC_ACC, DST_T3};   // t3=yn'
         // steps 27..28 run only when clamped
         5'd27: return '{OP_SUB, SRC_T3,  SRC_POS, DST_NONE};
         5'd28: return '{OP_DIV, SRC_ACC, SRC_DT,  DST_NONE};
         default: return '{OP_MOV, SRC_T4, SRC_T4, DST_NONE}; // restore vn
      endcase
   endfunction

   uop_type u;
   assign u = prog(pc_ff);

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      rv_in    = rv_ff && !rsp_ready;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               pc_in    = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.start = 1'b1;
            cmd.op    = u.op;
            cmd.src_a = u.a;
            cmd.src_b = u.b;
            cmd.dst   = u.dst;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.done) begin
               if (pc_ff == 5'd26 && sts.limited) pc_in = 5'd27;
               else if (pc_ff == 5'd26) pc_in = 5'd29;
               else pc_in = pc_ff + 5'd1;
               if (pc_ff == 5'd28 || pc_ff == 5'(NSTEP - 1)) state_in = ST_DONE;
               else state_in = ST_ISSUE;
            end
         end
         ST_DONE: begin
            // hold the commit while the previous result still waits
            if (!rv_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               rv_in      = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         rv_ff    <= rv_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rv_ff;
endmodule
`default_nettype wire

FILE: src/spring_damper_rk2_step.sv
// Top level of the spring-damper RK2 step block: configuration registers,
// controller and datapath. Depends on sdrk_pkg, sdrk_control, sdrk_datapath.
//
//  channel | ports                          | direction
//  req     | req_valid req_ready req_data   | in  (time_step, force_in)
//  rsp     | rsp_valid rsp_ready rsp_data   | out (displacement, speed, flags)
//  csr     | csr_we csr_index csr_wdata     | in  (register writes)
//
// A transaction runs to its result before the next one is accepted, and takes
// longer when the position is clamped. Each division takes one quotient bit a
// cycle over DATA_WIDTH+FRAC_BITS bits, and a zero divisor ends a division
// without quotient steps; each multiply is split. The block takes one
// transaction at a time; a result held by rsp_ready stalls the next commit.
// Reset clears state and registers to their defaults.
`default_nettype none
module spring_damper_rk2_step import sdrk_pkg::*; #(
   parameter int DATA_WIDTH = DataWidthDef,
   parameter int FRAC_BITS  = FracBitsDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   logic [30:0] mass_ff, limit_ff;
   logic [31:0] damping_ff, stiffness_ff, gain_ff;
   cmd_type cmd;
   sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff      <= 31'd65536;
         damping_ff   <= '0;
         stiffness_ff <= '0;
         gain_ff      <= 32'd65536;
         limit_ff     <= 31'h7FFFFFFF;
      end else if (csr_we) begin
         case (csr_index)
            REG_MASS:       mass_ff      <= csr_wdata[30:0];
            REG_DAMPING:    damping_ff   <= csr_wdata;
            REG_STIFFNESS:  stiffness_ff <= csr_wdata;
            REG_FORCE_GAIN: gain_ff      <= csr_wdata;
            REG_DISP_LIMIT: limit_ff     <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   sdrk_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .sts
   );

   sdrk_datapath #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock, .reset, .cmd, .sts, .req(req_data),
      .mass(mass_ff), .damping(damping_ff), .stiffness(stiffness_ff),
      .force_gain(gain_ff), .disp_limit(limit_ff), .result(rsp_data)
   );
endmodule
`default_nettype wire
